// File: hdl/srwc_pkg.sv
`default_nettype none
package srwc_pkg;

  localparam int MAX_WINDOW_DEF = 8;
  localparam int NUM_TYPES_DEF  = 3;

  localparam int ROW_W       = 21;
  localparam int TYPE_W      = 2;
  localparam int SLOT_W      = 3;
  localparam int WROWS_W     = 4;
  localparam int REGION_W    = 20;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_INDEX_W = 2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_CACHE_ENABLE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_ROWS  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_REGION_ROWS  = 2'd2;

  typedef struct packed {
    logic signed [ROW_W-1:0] row;
    logic [TYPE_W-1:0]       buf_type;
  } req_t;

  typedef struct packed {
    logic              null_row;
    logic              fetch;
    logic [SLOT_W-1:0] slot;
  } rsp_t;

  typedef struct packed {
    logic                   we;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_COMMIT
  } state_t;

  typedef enum logic [2:0] {
    CLS_NULL,
    CLS_DIRECT,
    CLS_HIT,
    CLS_FAR,
    CLS_SLIDE
  } cls_t;

  typedef struct packed {
    logic load;
    logic classify;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rsp_stall;
  } dp_status_t;

endpackage
`default_nettype wire

// File: hdl/srwc_ctrl.sv
`default_nettype none
module srwc_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    req_valid,
  output logic                   req_ready,
  input  srwc_pkg::dp_status_t   status,
  output srwc_pkg::ctrl_cmd_t    cmd
);
  import srwc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold until the result register can take the beat
        if (!status.rsp_stall) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready    = (state == ST_IDLE);
    cmd.load     = (state == ST_IDLE) && req_valid;
    cmd.classify = (state == ST_CLASSIFY);
    cmd.commit   = (state == ST_COMMIT) && !status.rsp_stall;
  end

endmodule
`default_nettype wire

// File: hdl/srwc_datapath.sv
`default_nettype none
module srwc_datapath #(
  parameter int MAX_WINDOW = srwc_pkg::MAX_WINDOW_DEF,
  parameter int NUM_TYPES  = srwc_pkg::NUM_TYPES_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  srwc_pkg::cfg_wr_t    cfg,
  input  srwc_pkg::req_t       req_data,
  input  srwc_pkg::ctrl_cmd_t  cmd,
  output srwc_pkg::dp_status_t status,
  output logic                 rsp_valid,
  input  wire                  rsp_ready,
  output srwc_pkg::rsp_t       rsp_data
);
  import srwc_pkg::*;

  localparam int SW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WSW = $clog2(MAX_WINDOW + 1);
  localparam int CW  = (WSW > WROWS_W) ? WSW : WROWS_W;
  localparam int TW  = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int LW  = SW + 2;
  localparam int IW  = ROW_W + 2;

  // configuration
  logic                cache_enable;
  logic [WROWS_W-1:0]  window_rows;
  logic [REGION_W-1:0] region_rows;

  // per-type window state; the slot map is always a rotation, kept as an offset
  logic [NUM_TYPES-1:0]    type_used;
  logic [MAX_WINDOW-1:0]   valid_bits [NUM_TYPES];
  logic signed [ROW_W-1:0] base_row   [NUM_TYPES];
  logic [SW-1:0]           rot        [NUM_TYPES];

  // request capture
  logic signed [ROW_W-1:0] req_row;
  logic [TYPE_W-1:0]       req_type;

  // classify results
  cls_t                    cls;
  logic signed [IW-1:0]    idx_i;
  logic [WSW-1:0]          wsz;
  logic [MAX_WINDOW-1:0]   v_cur;
  logic [SW-1:0]           r_cur;
  logic signed [ROW_W-1:0] base_cur;

  function automatic logic [SW-1:0] mod_add(input logic [SW-1:0] a, input logic [SW-1:0] b,
                                            input logic [WSW-1:0] w);
    logic [SW:0] s;
    logic [SW:0] wl;
    s  = {1'b0, a} + {1'b0, b};
    wl = (SW + 1)'(w);
    if (s >= wl) s = s - wl;
    return s[SW-1:0];
  endfunction

  // ---------------------------------------------------------------- classify
  logic [TW-1:0]           c_t;
  logic                    c_type_ok;
  logic [CW-1:0]           c_wext;
  logic [WSW-1:0]          c_wsize;
  logic                    c_used;
  logic signed [ROW_W-1:0] c_base;
  logic signed [IW-1:0]    c_i;
  logic signed [IW-1:0]    c_w;
  logic signed [IW-1:0]    c_wneg;
  logic signed [IW-1:0]    c_w2m1;
  logic                    c_null;
  cls_t                    c_cls;

  always_comb begin
    c_t       = req_type[TW-1:0];
    c_type_ok = ({1'b0, req_type} < (TYPE_W + 1)'(NUM_TYPES));
    c_wext    = CW'(window_rows);
    if (c_wext < CW'(2)) c_wext = CW'(2);
    if (c_wext > CW'(MAX_WINDOW)) c_wext = CW'(MAX_WINDOW);
    c_wsize = c_wext[WSW-1:0];
    c_used  = type_used[c_t];
    // first use of a type starts with the window just below row zero
    c_base  = c_used ? base_row[c_t] : (ROW_W'(0) - ROW_W'(c_wsize));
    c_i     = {{2{req_row[ROW_W-1]}}, req_row} - {{2{c_base[ROW_W-1]}}, c_base};
    c_w     = {{(IW - WSW){1'b0}}, c_wsize};
    c_wneg  = -c_w;
    c_w2m1  = c_w + c_w - $signed(IW'(1));
    c_null  = !c_type_ok || req_row[ROW_W-1] || (req_row[ROW_W-2:0] >= region_rows);
    if (c_null) begin
      c_cls = CLS_NULL;
    end else if (!cache_enable) begin
      c_cls = CLS_DIRECT;
    end else if (!c_i[IW-1] && (c_i < c_w)) begin
      c_cls = CLS_HIT;
    end else if ((c_i <= c_wneg) || (c_i >= c_w2m1)) begin
      c_cls = CLS_FAR;
    end else begin
      c_cls = CLS_SLIDE;
    end
  end

  // ------------------------------------------------------------------ commit
  logic [TW-1:0]           m_t;
  logic [MAX_WINDOW-1:0]   m_wmask;
  logic [SW-1:0]           m_idx;
  logic                    m_neg;
  logic [SW-1:0]           m_wm1;
  logic [SW-1:0]           m_e;
  logic signed [LW-1:0]    m_d;
  logic signed [LW-1:0]    m_dneg;
  logic signed [LW-1:0]    m_wl;
  logic signed [LW-1:0]    m_rsum;
  logic [SW-1:0]           m_rnew;
  logic [SW-1:0]           m_amt;
  logic [MAX_WINDOW-1:0]   m_vm;
  logic [MAX_WINDOW-1:0]   m_vslide;
  logic [MAX_WINDOW-1:0]   m_vhit;
  logic signed [ROW_W-1:0] m_base_slide;
  logic [SW-1:0]           m_pos;
  logic [SW+SLOT_W-1:0]    m_pos_ext;
  rsp_t                    m_rsp;

  always_comb begin
    m_t = req_type[TW-1:0];
    for (int j = 0; j < MAX_WINDOW; j++) begin
      m_wmask[j] = (WSW'(j) < wsz);
    end
    m_idx  = idx_i[SW-1:0];
    m_neg  = idx_i[IW-1];
    m_wm1  = SW'(wsz - WSW'(1));
    m_e    = m_neg ? '0 : m_wm1;
    // window shift: below the window the new base is the row, above it row - (w-1)
    m_d    = m_neg ? idx_i[LW-1:0] : (idx_i[LW-1:0] - $signed(LW'(m_wm1)));
    m_dneg = -m_d;
    m_wl   = $signed(LW'(wsz));
    m_rsum = $signed(LW'(r_cur)) + m_d;
    if (m_rsum[LW-1]) begin
      m_rsum = m_rsum + m_wl;
    end else if (m_rsum >= m_wl) begin
      m_rsum = m_rsum - m_wl;
    end
    m_rnew   = m_rsum[SW-1:0];
    m_amt    = m_neg ? m_dneg[SW-1:0] : m_d[SW-1:0];
    m_vm     = v_cur & m_wmask;
    m_vslide = m_neg ? ((m_vm << m_amt) & m_wmask) : (m_vm >> m_amt);
    m_vslide = m_vslide | (MAX_WINDOW'(1) << m_e);
    m_vhit   = v_cur | (MAX_WINDOW'(1) << m_idx);
    m_base_slide = req_row - $signed(ROW_W'(m_e));

    m_pos = '0;
    case (cls)
      CLS_HIT:   m_pos = mod_add(m_idx, r_cur, wsz);
      CLS_FAR:   m_pos = r_cur;
      CLS_SLIDE: m_pos = mod_add(m_e, m_rnew, wsz);
      default:   m_pos = '0;
    endcase
    m_pos_ext = {{SLOT_W{1'b0}}, m_pos};

    m_rsp.null_row = 1'b0;
    m_rsp.fetch    = 1'b1;
    m_rsp.slot     = m_pos_ext[SLOT_W-1:0];
    case (cls)
      CLS_NULL: begin
        m_rsp.null_row = 1'b1;
        m_rsp.fetch    = 1'b0;
        m_rsp.slot     = '0;
      end
      CLS_DIRECT: m_rsp.slot  = '0;
      CLS_HIT:    m_rsp.fetch = !v_cur[m_idx];
      default:    m_rsp.fetch = 1'b1;
    endcase
  end

  // --------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cache_enable <= 1'b1;
      window_rows  <= WROWS_W'(8);
      region_rows  <= REGION_W'(1);
      type_used    <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cmd.commit && (cls == CLS_HIT || cls == CLS_FAR || cls == CLS_SLIDE)) begin
        type_used[m_t] <= 1'b1;
      end
      if (cfg.we) begin
        case (cfg.index)
          CFG_CACHE_ENABLE: cache_enable <= cfg.data[0];
          CFG_WINDOW_ROWS: begin
            window_rows <= cfg.data[WROWS_W-1:0];
            type_used   <= '0;  // every window discarded
          end
          CFG_REGION_ROWS: region_rows <= cfg.data[REGION_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_row  <= req_data.row;
      req_type <= req_data.buf_type;
    end
    if (cmd.classify) begin
      cls      <= c_cls;
      idx_i    <= c_i;
      wsz      <= c_wsize;
      v_cur    <= c_used ? valid_bits[c_t] : '0;
      r_cur    <= c_used ? rot[c_t] : '0;
      base_cur <= c_base;
    end
    if (cmd.commit) begin
      rsp_data <= m_rsp;
      case (cls)
        CLS_HIT: begin
          valid_bits[m_t] <= m_vhit;
          base_row[m_t]   <= base_cur;
          rot[m_t]        <= r_cur;
        end
        CLS_FAR: begin
          valid_bits[m_t] <= MAX_WINDOW'(1);
          base_row[m_t]   <= req_row;
          rot[m_t]        <= r_cur;
        end
        CLS_SLIDE: begin
          valid_bits[m_t] <= m_vslide;
          base_row[m_t]   <= m_base_slide;
          rot[m_t]        <= m_rnew;
        end
        default: ;
      endcase
    end
  end

  assign status.rsp_stall = rsp_valid && !rsp_ready;

endmodule
`default_nettype wire

// File: hdl/sliding_row_window_cache_unit.sv
`default_nettype none
// Row window cache controller. Each request beat names a row and a cell type
// and returns one beat: null_row when the row lies outside the region, fetch
// when the caller must read the row into the returned slot, and the slot. A
// request passes capture, classify against the type's window and commit of
// window state and result; commit waits while an earlier result is still held
// in the output register, and the next request is captured while a result
// waits. A slide moves the slot rotation offset and shifts the valid marks in
// the commit cycle; a rebase keeps the offset and marks only the new row.
// Writing window_rows discards all windows; no clearing pass is needed.
// Configuration must be written only while no request is in flight.
module sliding_row_window_cache_unit #(
  parameter int MAX_WINDOW = srwc_pkg::MAX_WINDOW_DEF,
  parameter int NUM_TYPES  = srwc_pkg::NUM_TYPES_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  req_valid,
  output logic                                 req_ready,
  input  srwc_pkg::req_t                       req_data,
  output logic                                 rsp_valid,
  input  wire                                  rsp_ready,
  output srwc_pkg::rsp_t                       rsp_data,
  input  wire                                  cfg_we,
  input  wire [srwc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire [srwc_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import srwc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  cfg_wr_t    cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  srwc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  srwc_datapath #(
    .MAX_WINDOW (MAX_WINDOW),
    .NUM_TYPES  (NUM_TYPES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_data  (req_data),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

endmodule
`default_nettype wire
